FILE: rtl/lef_pkg.sv
package lef_pkg;

    localparam int CHANNEL_BITS       = 8;
    localparam int MAX_WIDTH          = 512;

    localparam int LINE_WIDTH_BITS    = 10;
    localparam int FRAME_HEIGHT_BITS  = 13;
    localparam int CFG_DATA_BITS      = 13;
    localparam int CFG_IDX_BITS       = 1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_WIDTH   = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam int LINE_WIDTH_RESET   = 512;
    localparam int FRAME_HEIGHT_RESET = 512;
    localparam int HEIGHT_LIMIT       = 4096;
    localparam int ROW_BITS           = 12;

    localparam int QDEPTH             = 4;
    localparam int QPTR_BITS          = $clog2(QDEPTH);
    localparam int QCNT_BITS          = $clog2(QDEPTH + 1);
    localparam int FLIGHT_BITS        = $clog2(QDEPTH + 3);

    typedef struct packed {
        logic emit;
        logic left;
        logic right;
        logic top;
        logic bottom;
        logic last;
    } t_edge_flags;

endpackage

FILE: rtl/laplacian_edge_filter_3x3_core.sv
// Channel   Direction  Handshake            Payload
// pixel     in         i_valid / o_ready    i_pixel_red, i_pixel_green, i_pixel_blue, i_flush
// edge      out        o_valid / i_ready    o_edge_red, o_edge_green, o_edge_blue, o_frame_last
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// One item is taken per clock while o_ready is high and i_cfg_we is low.
// The line buffer read and its write-back of the previous item set the pace of one item a cycle.
// Synchronous reset clears the counters, the pipeline and the four-entry result queue.
// When results are not taken, o_ready drops once the queue could fill with items in flight.
module laplacian_edge_filter_3x3_core #(
    parameter int MAX_WIDTH    = lef_pkg::MAX_WIDTH,
    parameter int CHANNEL_BITS = lef_pkg::CHANNEL_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [CHANNEL_BITS-1:0]            i_pixel_red,
    input  logic [CHANNEL_BITS-1:0]            i_pixel_green,
    input  logic [CHANNEL_BITS-1:0]            i_pixel_blue,
    input  logic                               i_flush,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [CHANNEL_BITS-1:0]            o_edge_red,
    output logic [CHANNEL_BITS-1:0]            o_edge_green,
    output logic [CHANNEL_BITS-1:0]            o_edge_blue,
    output logic                               o_frame_last,
    input  logic                               i_cfg_we,
    input  logic [lef_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [lef_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int PIX_BITS = 3 * CHANNEL_BITS;
    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int ROW_BITS = lef_pkg::ROW_BITS;

    logic [lef_pkg::LINE_WIDTH_BITS-1:0]   r_line_width;
    logic [lef_pkg::FRAME_HEIGHT_BITS-1:0] r_frame_height;

    logic [COL_BITS-1:0] r_in_col, n_in_col;
    logic [1:0]          r_in_rows, n_in_rows;
    logic [COL_BITS-1:0] r_out_col, n_out_col;
    logic [ROW_BITS-1:0] r_out_row, n_out_row;

    logic [COL_BITS-1:0] w_m1;
    logic [ROW_BITS-1:0] h_m1;

    logic                 in_acc;
    logic [PIX_BITS-1:0]  in_pix;
    lef_pkg::t_edge_flags flags;

    logic                 r1_valid;
    logic [COL_BITS-1:0]  r1_addr;
    logic [PIX_BITS-1:0]  r1_pix;
    lef_pkg::t_edge_flags r1_flags;
    logic                 r2_valid;
    lef_pkg::t_edge_flags r2_flags;

    logic [PIX_BITS-1:0]  above;
    logic [PIX_BITS-1:0]  middle;
    logic [PIX_BITS-1:0]  r_win [0:2][0:2];
    logic [PIX_BITS-1:0]  win_col [0:2];

    logic [CHANNEL_BITS-1:0]       lane_out [0:2];
    logic                          q_push;
    logic [lef_pkg::QCNT_BITS-1:0] q_count;
    logic [lef_pkg::FLIGHT_BITS-1:0] flight;

    always_comb begin
        if (r_line_width == '0) begin
            w_m1 = '0;
        end else if (32'(r_line_width) > MAX_WIDTH) begin
            w_m1 = COL_BITS'(MAX_WIDTH - 1);
        end else begin
            w_m1 = COL_BITS'(32'(r_line_width) - 1);
        end
        if (r_frame_height == '0) begin
            h_m1 = '0;
        end else if (32'(r_frame_height) > lef_pkg::HEIGHT_LIMIT) begin
            h_m1 = ROW_BITS'(lef_pkg::HEIGHT_LIMIT - 1);
        end else begin
            h_m1 = ROW_BITS'(32'(r_frame_height) - 1);
        end
    end

    assign flight = lef_pkg::FLIGHT_BITS'(q_count)
                  + lef_pkg::FLIGHT_BITS'(r1_valid && r1_flags.emit)
                  + lef_pkg::FLIGHT_BITS'(r2_valid && r2_flags.emit);
    assign o_ready = (32'(flight) < lef_pkg::QDEPTH);
    assign in_acc  = i_valid && o_ready && !i_cfg_we;
    assign in_pix  = i_flush ? '0 : {i_pixel_blue, i_pixel_green, i_pixel_red};

    always_comb begin
        flags.emit   = r_in_rows[1] || (r_in_rows == 2'd1 && r_in_col != '0);
        flags.left   = (r_out_col == '0);
        flags.right  = (r_out_col == w_m1);
        flags.top    = (r_out_row == '0);
        flags.bottom = (r_out_row == h_m1);
        flags.last   = flags.right && flags.bottom;
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_rows = r_in_rows;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (i_cfg_we || (in_acc && flags.emit && flags.last)) begin
            n_in_col  = '0;
            n_in_rows = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (in_acc) begin
            if (r_in_col == w_m1) begin
                n_in_col = '0;
                if (!r_in_rows[1]) begin
                    n_in_rows = r_in_rows + 2'd1;
                end
            end else begin
                n_in_col = r_in_col + 1'b1;
            end
            if (flags.emit) begin
                if (flags.right) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + 1'b1;
                end else begin
                    n_out_col = r_out_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= lef_pkg::LINE_WIDTH_BITS'(lef_pkg::LINE_WIDTH_RESET);
            r_frame_height <= lef_pkg::FRAME_HEIGHT_BITS'(lef_pkg::FRAME_HEIGHT_RESET);
            r_in_col       <= '0;
            r_in_rows      <= '0;
            r_out_col      <= '0;
            r_out_row      <= '0;
            r1_valid       <= 1'b0;
            r2_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lef_pkg::CFG_LINE_WIDTH: begin
                        r_line_width <= i_cfg_data[lef_pkg::LINE_WIDTH_BITS-1:0];
                    end
                    lef_pkg::CFG_FRAME_HEIGHT: begin
                        r_frame_height <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            r_in_col  <= n_in_col;
            r_in_rows <= n_in_rows;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r1_valid  <= in_acc;
            r2_valid  <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r1_addr  <= r_in_col;
            r1_pix   <= in_pix;
            r1_flags <= flags;
        end
        if (r1_valid) begin
            r2_flags <= r1_flags;
        end
    end

    lef_line_buffer #(
        .CHANNEL_BITS (CHANNEL_BITS),
        .MAX_WIDTH    (MAX_WIDTH)
    ) u_line_buffer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_in_col),
        .i_wr_en   (r1_valid),
        .i_wr_addr (r1_addr),
        .i_wr_pix  (r1_pix),
        .o_above   (above),
        .o_middle  (middle)
    );

    assign win_col[0] = above;
    assign win_col[1] = middle;
    assign win_col[2] = r1_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (r1_valid) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
                r_win[r][2] <= win_col[r];
            end
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
        logic [CHANNEL_BITS-1:0] lane_taps [0:2][0:2];

        always_comb begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    lane_taps[r][c] = r_win[r][c][k*CHANNEL_BITS +: CHANNEL_BITS];
                end
            end
        end

        lef_lane #(
            .CHANNEL_BITS (CHANNEL_BITS)
        ) u_lane (
            .i_taps  (lane_taps),
            .i_flags (r2_flags),
            .o_edge  (lane_out[k])
        );
    end

    assign q_push = r2_valid && r2_flags.emit;

    lef_merge #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_lane       (lane_out),
        .i_last       (r2_flags.last),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_edge_red   (o_edge_red),
        .o_edge_green (o_edge_green),
        .o_edge_blue  (o_edge_blue),
        .o_frame_last (o_frame_last),
        .o_count      (q_count)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && (32'(q_count) == lef_pkg::QDEPTH) && !(o_valid && i_ready)))
        else $error("result queue written while full");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && flags.emit && flags.last) |=>
        (r_in_col == '0 && r_in_rows == 2'd0 && r_out_col == '0 && r_out_row == '0))
        else $error("counters not restarted after the last pixel of a frame");

    a_pipe_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r1_valid |=> (r2_valid && r2_flags == $past(r1_flags)))
        else $error("stage two did not take the item from stage one");

endmodule

FILE: rtl/lef_line_buffer.sv
module lef_line_buffer #(
    parameter int CHANNEL_BITS = lef_pkg::CHANNEL_BITS,
    parameter int MAX_WIDTH    = lef_pkg::MAX_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]    i_rd_addr,
    input  logic                            i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]    i_wr_addr,
    input  logic [3*CHANNEL_BITS-1:0]       i_wr_pix,
    output logic [3*CHANNEL_BITS-1:0]       o_above,
    output logic [3*CHANNEL_BITS-1:0]       o_middle
);

    localparam int PIX_BITS  = 3 * CHANNEL_BITS;
    localparam int WORD_BITS = 2 * PIX_BITS;

    // Each word holds the middle row pixel in the upper half and the row above below it.
    logic [WORD_BITS-1:0] r_mem [0:MAX_WIDTH-1];
    logic [WORD_BITS-1:0] r_rd;
    logic [WORD_BITS-1:0] r_byp_data;
    logic                 r_byp_hit;
    logic [WORD_BITS-1:0] rd_word;
    logic [WORD_BITS-1:0] wr_word;
    logic                 byp_hit;

    assign rd_word  = r_byp_hit ? r_byp_data : r_rd;
    assign o_middle = rd_word[WORD_BITS-1:PIX_BITS];
    assign o_above  = rd_word[PIX_BITS-1:0];
    assign wr_word  = {i_wr_pix, o_middle};
    assign byp_hit  = i_wr_en && (i_rd_addr == i_wr_addr);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= wr_word;
        end
        if (i_rd_en) begin
            r_rd       <= r_mem[i_rd_addr];
            r_byp_data <= wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_byp_hit <= byp_hit;
        end
    end

endmodule

FILE: rtl/lef_lane.sv
module lef_lane #(
    parameter int CHANNEL_BITS = lef_pkg::CHANNEL_BITS
) (
    input  logic [CHANNEL_BITS-1:0] i_taps [0:2][0:2],
    input  lef_pkg::t_edge_flags    i_flags,
    output logic [CHANNEL_BITS-1:0] o_edge
);

    localparam int SUM_BITS = CHANNEL_BITS + 3;
    localparam int ACC_BITS = CHANNEL_BITS + 5;

    logic [1:0]                 rsel [0:2];
    logic [1:0]                 csel [0:2];
    logic [SUM_BITS-1:0]        sum;
    logic [SUM_BITS-1:0]        center8;
    logic signed [ACC_BITS-1:0] acc;

    always_comb begin
        rsel[0] = i_flags.top    ? 2'd1 : 2'd0;
        rsel[1] = 2'd1;
        rsel[2] = i_flags.bottom ? 2'd1 : 2'd2;
        csel[0] = i_flags.left   ? 2'd1 : 2'd0;
        csel[1] = 2'd1;
        csel[2] = i_flags.right  ? 2'd1 : 2'd2;
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (!(i == 1 && j == 1)) begin
                    sum = sum + SUM_BITS'(i_taps[rsel[i]][csel[j]]);
                end
            end
        end
        center8 = {i_taps[1][1], 3'b000};
        acc = $signed({2'b00, center8}) - $signed({2'b00, sum});
        if (acc[ACC_BITS-1]) begin
            o_edge = '0;
        end else if (|acc[ACC_BITS-2:CHANNEL_BITS]) begin
            o_edge = '1;
        end else begin
            o_edge = acc[CHANNEL_BITS-1:0];
        end
    end

endmodule

FILE: rtl/lef_merge.sv
module lef_merge #(
    parameter int CHANNEL_BITS = lef_pkg::CHANNEL_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  logic [CHANNEL_BITS-1:0]          i_lane [0:2],
    input  logic                             i_last,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [CHANNEL_BITS-1:0]          o_edge_red,
    output logic [CHANNEL_BITS-1:0]          o_edge_green,
    output logic [CHANNEL_BITS-1:0]          o_edge_blue,
    output logic                             o_frame_last,
    output logic [lef_pkg::QCNT_BITS-1:0]    o_count
);

    localparam int DATA_BITS = 3 * CHANNEL_BITS + 1;

    logic [DATA_BITS-1:0]            r_data [0:lef_pkg::QDEPTH-1];
    logic [lef_pkg::QPTR_BITS-1:0]   r_wr_ptr;
    logic [lef_pkg::QPTR_BITS-1:0]   r_rd_ptr;
    logic [lef_pkg::QCNT_BITS-1:0]   r_count;
    logic [DATA_BITS-1:0]            head;
    logic                            pop;

    assign pop          = o_valid && i_ready;
    assign o_valid      = (r_count != '0);
    assign o_count      = r_count;
    assign head         = r_data[r_rd_ptr];
    assign o_frame_last = head[DATA_BITS-1];
    assign o_edge_blue  = head[3*CHANNEL_BITS-1:2*CHANNEL_BITS];
    assign o_edge_green = head[2*CHANNEL_BITS-1:CHANNEL_BITS];
    assign o_edge_red   = head[CHANNEL_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= {i_last, i_lane[2], i_lane[1], i_lane[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: bench/edge_stream_checker.sv
`timescale 1ns / 100ps

module edge_stream_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic                               o_ready,
    input  logic [lef_pkg::CHANNEL_BITS-1:0]   i_pixel_red,
    input  logic [lef_pkg::CHANNEL_BITS-1:0]   i_pixel_green,
    input  logic [lef_pkg::CHANNEL_BITS-1:0]   i_pixel_blue,
    input  logic                               i_flush,
    input  logic                               o_valid,
    input  logic                               i_ready,
    input  logic [lef_pkg::CHANNEL_BITS-1:0]   o_edge_red,
    input  logic [lef_pkg::CHANNEL_BITS-1:0]   o_edge_green,
    input  logic [lef_pkg::CHANNEL_BITS-1:0]   o_edge_blue,
    input  logic                               o_frame_last,
    input  logic                               i_cfg_we,
    input  logic [lef_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [lef_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output int                                 errors,
    output int                                 outstanding,
    output int                                 results_seen,
    output int                                 frames_seen
);

    localparam int CHANNEL_BITS      = lef_pkg::CHANNEL_BITS;
    localparam int MAX_WIDTH         = lef_pkg::MAX_WIDTH;
    localparam int HEIGHT_LIMIT      = lef_pkg::HEIGHT_LIMIT;
    localparam int LINE_WIDTH_BITS   = lef_pkg::LINE_WIDTH_BITS;
    localparam int FRAME_HEIGHT_BITS = lef_pkg::FRAME_HEIGHT_BITS;
    localparam int CHANNEL_MAX       = (1 << CHANNEL_BITS) - 1;

    typedef logic [3*CHANNEL_BITS-1:0] t_rgb;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
        logic                    last;
    } t_edge_item;

    t_rgb                        above_row [MAX_WIDTH];
    t_rgb                        middle_row [MAX_WIDTH];
    t_rgb                        window [9];
    logic [LINE_WIDTH_BITS-1:0]  width_reg;
    logic [FRAME_HEIGHT_BITS-1:0] height_reg;
    int unsigned                 in_col, in_row, out_col, out_row;
    t_edge_item                  expected_edges [$];

    task automatic restart_frame();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endtask

    task automatic shift_window(input t_rgb top, input t_rgb mid, input t_rgb bot);
        t_rgb column [3];
        column[0] = top;
        column[1] = mid;
        column[2] = bot;
        for (int r = 0; r < 3; r++) begin
            window[r*3]   = window[r*3+1];
            window[r*3+1] = window[r*3+2];
            window[r*3+2] = column[r];
        end
    endtask

    // Edge pixels stand in for neighbors that fall outside the image.
    function automatic t_edge_item laplace_window(input int unsigned left_col,
                                                  input int unsigned mid_col,
                                                  input int unsigned right_col,
                                                  input int unsigned w,
                                                  input int unsigned h);
        int unsigned             cols [3];
        int unsigned             rows [3];
        int                      acc;
        int                      v;
        logic [CHANNEL_BITS-1:0] level [3];
        t_edge_item              res;
        if (out_col == 0) left_col = mid_col;
        if (out_col + 1 >= w) right_col = mid_col;
        cols[0] = left_col;
        cols[1] = mid_col;
        cols[2] = right_col;
        rows[0] = (out_row == 0) ? 1 : 0;
        rows[1] = 1;
        rows[2] = (out_row + 1 >= h) ? 1 : 2;
        for (int k = 0; k < 3; k++) begin
            acc = 0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    v = int'(window[rows[i]*3 + cols[j]][k*CHANNEL_BITS +: CHANNEL_BITS]);
                    if (i == 1 && j == 1) acc += 8 * v;
                    else acc -= v;
                end
            end
            if (acc < 0) acc = 0;
            if (acc > CHANNEL_MAX) acc = CHANNEL_MAX;
            level[k] = acc[CHANNEL_BITS-1:0];
        end
        res.red   = level[0];
        res.green = level[1];
        res.blue  = level[2];
        res.last  = 1'b0;
        return res;
    endfunction

    task automatic advance_stream(input logic [CHANNEL_BITS-1:0] r,
                                  input logic [CHANNEL_BITS-1:0] g,
                                  input logic [CHANNEL_BITS-1:0] b,
                                  input logic f);
        int unsigned w, h, idx;
        t_rgb        pix, a, m;
        logic        emit;
        t_edge_item  res;
        w = 32'(width_reg);
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = 32'(height_reg);
        if (h < 1) h = 1;
        if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
        pix  = f ? '0 : {b, g, r};
        emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        idx  = (in_col < MAX_WIDTH) ? in_col : 0;
        a = above_row[idx];
        m = middle_row[idx];
        above_row[idx]  = m;
        middle_row[idx] = pix;
        if (in_col == 0) begin
            if (emit) res = laplace_window(1, 2, 2, w, h);
            shift_window(a, m, pix);
        end else begin
            shift_window(a, m, pix);
            if (emit) res = laplace_window(0, 1, 2, w, h);
        end
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (emit) begin
            res.last = (out_row + 1 >= h) && (out_col + 1 >= w);
            expected_edges.push_back(res);
            if (res.last) begin
                restart_frame();
            end else begin
                out_col++;
                if (out_col >= w) begin
                    out_col = 0;
                    out_row++;
                end
            end
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_edge_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_WIDTH; i++) begin
                above_row[i]  = '0;
                middle_row[i] = '0;
            end
            for (int i = 0; i < 9; i++) window[i] = '0;
            restart_frame();
            width_reg  = LINE_WIDTH_BITS'(lef_pkg::LINE_WIDTH_RESET);
            height_reg = FRAME_HEIGHT_BITS'(lef_pkg::FRAME_HEIGHT_RESET);
            expected_edges.delete();
            errors       = 0;
            results_seen = 0;
            frames_seen  = 0;
        end else begin
            if (o_valid && i_ready) begin
                results_seen++;
                if (o_frame_last) frames_seen++;
                if (expected_edges.size() == 0) begin
                    $display("%0t ns: no result expected, got red %0d green %0d",
                             $time, o_edge_red, o_edge_green);
                    $display("%0t ns: blue %0d last %0d", $time, o_edge_blue, o_frame_last);
                    errors++;
                end else begin
                    want = expected_edges.pop_front();
                    check_field("edge_red", int'(want.red), int'(o_edge_red));
                    check_field("edge_green", int'(want.green), int'(o_edge_green));
                    check_field("edge_blue", int'(want.blue), int'(o_edge_blue));
                    check_field("frame_last", int'(want.last), int'(o_frame_last));
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == lef_pkg::CFG_LINE_WIDTH) begin
                    width_reg = i_cfg_data[LINE_WIDTH_BITS-1:0];
                end else begin
                    height_reg = i_cfg_data[FRAME_HEIGHT_BITS-1:0];
                end
                restart_frame();
            end
            if (i_valid && o_ready) begin
                advance_stream(i_pixel_red, i_pixel_green, i_pixel_blue, i_flush);
            end
        end
        outstanding = expected_edges.size();
    end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int CHANNEL_BITS  = lef_pkg::CHANNEL_BITS;
    localparam int CFG_IDX_BITS  = lef_pkg::CFG_IDX_BITS;
    localparam int CFG_DATA_BITS = lef_pkg::CFG_DATA_BITS;
    localparam int MAX_WIDTH     = lef_pkg::MAX_WIDTH;

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_valid       = 1'b0;
    logic                      o_ready;
    logic [CHANNEL_BITS-1:0]   i_pixel_red   = '0;
    logic [CHANNEL_BITS-1:0]   i_pixel_green = '0;
    logic [CHANNEL_BITS-1:0]   i_pixel_blue  = '0;
    logic                      i_flush       = 1'b0;
    logic                      o_valid;
    logic                      i_ready       = 1'b0;
    logic [CHANNEL_BITS-1:0]   o_edge_red;
    logic [CHANNEL_BITS-1:0]   o_edge_green;
    logic [CHANNEL_BITS-1:0]   o_edge_blue;
    logic                      o_frame_last;
    logic                      i_cfg_we      = 1'b0;
    logic [CFG_IDX_BITS-1:0]   i_cfg_idx     = lef_pkg::CFG_LINE_WIDTH;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data    = '0;

    int errors;
    int outstanding;
    int results_seen;
    int frames_seen;
    int items_sent     = 0;
    int settings_used  = 0;

    always #2 i_clk = ~i_clk;

    laplacian_edge_filter_3x3_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pixel_red   (i_pixel_red),
        .i_pixel_green (i_pixel_green),
        .i_pixel_blue  (i_pixel_blue),
        .i_flush       (i_flush),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_edge_red    (o_edge_red),
        .o_edge_green  (o_edge_green),
        .o_edge_blue   (o_edge_blue),
        .o_frame_last  (o_frame_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    edge_stream_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pixel_red   (i_pixel_red),
        .i_pixel_green (i_pixel_green),
        .i_pixel_blue  (i_pixel_blue),
        .i_flush       (i_flush),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_edge_red    (o_edge_red),
        .o_edge_green  (o_edge_green),
        .o_edge_blue   (o_edge_blue),
        .o_frame_last  (o_frame_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .errors        (errors),
        .outstanding   (outstanding),
        .results_seen  (results_seen),
        .frames_seen   (frames_seen)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [CHANNEL_BITS-1:0] pick_level();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return CHANNEL_BITS'($urandom_range(0, (1 << CHANNEL_BITS) - 1));
    endfunction

    task automatic push_pixel(input logic [CHANNEL_BITS-1:0] r,
                              input logic [CHANNEL_BITS-1:0] g,
                              input logic [CHANNEL_BITS-1:0] b,
                              input logic f);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_pixel_red   <= r;
        i_pixel_green <= g;
        i_pixel_blue  <= b;
        i_flush       <= f;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic push_random(input int flush_pct);
        push_pixel(pick_level(), pick_level(), pick_level(),
                   $urandom_range(0, 99) < flush_pct);
    endtask

    // Waits until every result is out and the pipeline has drained.
    task automatic settle();
        i_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_geometry(input int w, input int h);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= lef_pkg::CFG_LINE_WIDTH;
        i_cfg_data <= CFG_DATA_BITS'(w);
        @(negedge i_clk);
        i_cfg_idx  <= lef_pkg::CFG_FRAME_HEIGHT;
        i_cfg_data <= CFG_DATA_BITS'(h);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        settings_used++;
    endtask

    initial begin
        int iter;
        int hold;
        int run;
        iter = 0;
        forever begin
            hold = pick_gap();
            if (iter % 120 == 40) hold = 300;
            if (hold > 0) begin
                i_ready <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            run = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 8);
            repeat (run) @(negedge i_clk);
            iter++;
        end
    end

    initial begin
        #4_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int w, h, w_used, h_used, tail, n;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_geometry(3, 2);
        push_pixel(8'd255, 8'd0, 8'd255, 1'b0);
        push_pixel(8'd0, 8'd255, 8'd0, 1'b0);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        push_pixel(8'hAA, 8'h55, 8'hFF, 1'b1);
        push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        push_pixel(8'd255, 8'd0, 8'd128, 1'b0);
        push_pixel(8'd17, 8'd34, 8'd51, 1'b0);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        push_pixel(8'd0, 8'd0, 8'd0, 1'b1);

        set_geometry(0, 0);
        push_pixel(8'd200, 8'd100, 8'd50, 1'b0);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        push_pixel(8'd9, 8'd9, 8'd9, 1'b0);

        set_geometry(1, 3);
        push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        push_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        push_pixel(8'd0, 8'd0, 8'd0, 1'b1);

        while (items_sent < 580) begin
            if ($urandom_range(0, 4) == 0) begin
                set_geometry($urandom_range(0, 1023), $urandom_range(0, 8191));
                n = $urandom_range(16, 96);
                repeat (n) push_random(30);
            end else begin
                n = $urandom_range(0, 19);
                if (n == 0) w = 0;
                else if (n < 15) w = $urandom_range(1, 8);
                else w = $urandom_range(9, 24);
                n = $urandom_range(0, 19);
                if (n == 0) h = 0;
                else if (n < 18) h = $urandom_range(1, 6);
                else h = $urandom_range(7, 12);
                set_geometry(w, h);
                w_used = (w == 0) ? 1 : w;
                h_used = (h == 0) ? 1 : h;
                repeat ($urandom_range(1, 3)) begin
                    repeat (w_used * h_used) push_random(3);
                    tail = w_used + 1;
                    if ($urandom_range(0, 5) == 0) tail = $urandom_range(0, w_used + 3);
                    repeat (tail) push_random(70);
                end
            end
        end

        set_geometry(1023, 1);
        repeat (MAX_WIDTH + 8) push_random(30);
        set_geometry(1, 8191);
        repeat (40) push_random(5);

        settle();
        repeat (20) @(posedge i_clk);

        $display("Sent %0d pixel items over %0d register settings,", items_sent, settings_used);
        $display("clamped sizes and flushes included; checked %0d results, %0d closing a frame.",
                 results_seen, frames_seen);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
